FILE: hdl/qte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_pkg
// Shared widths, constants, pipeline types and helpers of the quaternion to
// euler angle converter.
// ----------------------------------------------------------------------------
package qte_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_LEN          = 24;

  localparam int IN_W     = 16;
  localparam int PROD_W   = 2 * IN_W;
  localparam int TERM_W   = 35;
  localparam int XY_W     = 37;
  localparam int Z_W      = 28;
  localparam int SQ_N_W   = 58;
  localparam int SQ_REM_W = 34;
  localparam int ROOT_W   = 29;
  localparam int SQRT_STAGES = 29;

  localparam logic signed [Z_W-1:0]    PI_Q24  = Z_W'(52707179);
  localparam logic signed [TERM_W-1:0] ONE_Q28 = TERM_W'(64'sd1 <<< 28);
  localparam logic [SQ_N_W-1:0]        ONE_Q56 = SQ_N_W'(1) << 56;

  localparam logic signed [15:0] PI_Q12      = 16'sd12868;
  localparam logic signed [15:0] HALF_PI_Q12 = 16'sd6434;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic                   zero;
    logic                   sat;
    logic                   pos;
  } cordic_t;

  typedef struct packed {
    logic [SQ_N_W-1:0]        n;
    logic [SQ_REM_W-1:0]      rem;
    logic [ROOT_W-1:0]        root;
    logic signed [ROOT_W-1:0] s;
    logic                     sat;
    logic                     pos;
  } sqrt_t;

  function automatic logic signed [Z_W-1:0] atan_q24(input int unsigned i);
    logic signed [Z_W-1:0] r;
    case (i)
      0:  r = Z_W'(13176795);
      1:  r = Z_W'(7778716);
      2:  r = Z_W'(4110060);
      3:  r = Z_W'(2086331);
      4:  r = Z_W'(1047214);
      5:  r = Z_W'(524117);
      6:  r = Z_W'(262123);
      7:  r = Z_W'(131069);
      8:  r = Z_W'(65536);
      9:  r = Z_W'(32768);
      10: r = Z_W'(16384);
      11: r = Z_W'(8192);
      12: r = Z_W'(4096);
      13: r = Z_W'(2048);
      14: r = Z_W'(1024);
      15: r = Z_W'(512);
      16: r = Z_W'(256);
      17: r = Z_W'(128);
      18: r = Z_W'(64);
      19: r = Z_W'(32);
      20: r = Z_W'(16);
      21: r = Z_W'(8);
      22: r = Z_W'(4);
      23: r = Z_W'(2);
      default: r = '0;
    endcase
    return r;
  endfunction

  // fold the left half plane onto the right one before the first rotation
  function automatic cordic_t cordic_pre(input logic signed [XY_W-1:0] y,
                                         input logic signed [XY_W-1:0] x,
                                         input logic sat, input logic pos);
    cordic_t r;
    r.zero = (x == '0) && (y == '0);
    r.sat  = sat;
    r.pos  = pos;
    if (x < 0) begin
      r.z = (y >= 0) ? PI_Q24 : -PI_Q24;
      r.x = -x;
      r.y = -y;
    end else begin
      r.z = '0;
      r.x = x;
      r.y = y;
    end
    return r;
  endfunction

endpackage

FILE: hdl/qte_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_sqrt_cell
// One digit of a restoring square root: takes two radicand bits, gives one
// root bit, and registers the partial result for the next cell.
// ----------------------------------------------------------------------------
module qte_sqrt_cell (
  input  logic            clk,
  input  logic            en,
  input  qte_pkg::sqrt_t  d,
  output qte_pkg::sqrt_t  q
);

  logic [qte_pkg::SQ_REM_W-1:0] cur;
  logic [qte_pkg::SQ_REM_W-1:0] trial;
  qte_pkg::sqrt_t               nxt;

  always_comb begin
    cur   = {d.rem[qte_pkg::SQ_REM_W-3:0], d.n[qte_pkg::SQ_N_W-1 -: 2]};
    trial = qte_pkg::SQ_REM_W'({d.root, 2'b01});
    nxt   = d;
    nxt.n = d.n << 2;
    if (cur >= trial) begin
      nxt.rem  = cur - trial;
      nxt.root = {d.root[qte_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      nxt.rem  = cur;
      nxt.root = {d.root[qte_pkg::ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= nxt;
    end
  end

endmodule

FILE: hdl/qte_cordic_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_cordic_cell
// One vectoring rotation of the arctangent chain, registered.
// ----------------------------------------------------------------------------
module qte_cordic_cell #(
  parameter int SHIFT = 0
) (
  input  logic             clk,
  input  logic             en,
  input  qte_pkg::cordic_t d,
  output qte_pkg::cordic_t q
);

  localparam logic signed [qte_pkg::Z_W-1:0] ANGLE = qte_pkg::atan_q24(SHIFT);

  logic signed [qte_pkg::XY_W-1:0] dx;
  logic signed [qte_pkg::XY_W-1:0] dy;
  qte_pkg::cordic_t                nxt;

  always_comb begin
    dx  = d.y >>> SHIFT;
    dy  = d.x >>> SHIFT;
    nxt = d;
    if (d.y > 0) begin
      nxt.x = d.x + dx;
      nxt.y = d.y - dy;
      nxt.z = d.z + ANGLE;
    end else begin
      nxt.x = d.x - dx;
      nxt.y = d.y + dy;
      nxt.z = d.z - ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= nxt;
    end
  end

endmodule

FILE: hdl/quaternion_to_euler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_to_euler
// Unit quaternion in Q1.14 to ZYX roll and yaw in Q2.12 and pitch in Q1.12 radians.
// ----------------------------------------------------------------------------
// One quaternion enters on the s_ channel per transfer, packed w, x, y, z
// from the lowest bit up. The angles leave on the m_ channel; m_tuser flags
// a pitch that was clamped to +-pi/2.
// Pipeline: products, sine and cosine terms, square of the pitch sine, a row
// of 29 square root cells, fold stage, CORDIC_STAGES rotation cells and a
// rounding stage. Roll and yaw are delayed after their rotation cells to
// line up with pitch, whose square root row makes its path the longest.
// Throughput is one transfer per cycle while m_tready lets the pipeline move:
// every cell hands its data to the next one each enabled cycle.
// When m_tready is low while a result is shown, the whole pipeline holds
// and s_tready drops; nothing is lost or repeated.
// Reset clears the valid flags only; the pipeline is empty afterwards and
// s_tready is high.
// ----------------------------------------------------------------------------
module quaternion_to_euler #(
  parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // quat_w, quat_x, quat_y, quat_z
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // roll_angle, pitch_angle, yaw_angle, zero fill
  output logic [0:0]  m_tuser    // pitch_saturated
);

  localparam int LAT    = CORDIC_STAGES + 34;
  localparam int RY_DLY = qte_pkg::SQRT_STAGES + 2;
  localparam int PW     = qte_pkg::PROD_W;
  localparam int TW     = qte_pkg::TERM_W;
  localparam int XW     = qte_pkg::XY_W;
  localparam int RW     = qte_pkg::ROOT_W;

  logic en;
  logic [LAT-1:0] vld;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  // products
  logic signed [qte_pkg::IN_W-1:0] qw, qx, qy, qz;
  logic signed [PW-1:0] p_wx, p_yz, p_xx, p_yy, p_wy, p_zx, p_wz, p_xy, p_zz;

  assign qw = s_tdata[15:0];
  assign qx = s_tdata[31:16];
  assign qy = s_tdata[47:32];
  assign qz = s_tdata[63:48];

  always_ff @(posedge clk) begin
    if (en) begin
      p_wx <= qw * qx;
      p_yz <= qy * qz;
      p_xx <= qx * qx;
      p_yy <= qy * qy;
      p_wy <= qw * qy;
      p_zx <= qz * qx;
      p_wz <= qw * qz;
      p_xy <= qx * qy;
      p_zz <= qz * qz;
    end
  end

  // sine and cosine terms, 28 fraction bits
  logic signed [TW-1:0] sinr, cosr, sinp, siny, cosy;

  always_ff @(posedge clk) begin
    if (en) begin
      sinr <= (TW'(p_wx) + TW'(p_yz)) <<< 1;
      cosr <= qte_pkg::ONE_Q28 - ((TW'(p_xx) + TW'(p_yy)) <<< 1);
      sinp <= (TW'(p_wy) - TW'(p_zx)) <<< 1;
      siny <= (TW'(p_wz) + TW'(p_xy)) <<< 1;
      cosy <= qte_pkg::ONE_Q28 - ((TW'(p_yy) + TW'(p_zz)) <<< 1);
    end
  end

  // square of the pitch sine; out of range terms only raise the flag
  logic signed [RW-1:0]               ps;
  logic [qte_pkg::SQ_N_W-1:0]         psq;
  logic                               psat, ppos;
  logic signed [qte_pkg::SQ_N_W-1:0]  psq_full;

  assign psq_full = $signed(sinp[RW-1:0]) * $signed(sinp[RW-1:0]);

  always_ff @(posedge clk) begin
    if (en) begin
      ps   <= sinp[RW-1:0];
      psq  <= psq_full;
      psat <= (sinp >= qte_pkg::ONE_Q28) || (sinp <= -qte_pkg::ONE_Q28);
      ppos <= sinp > 0;
    end
  end

  // square root row for the pitch cosine
  qte_pkg::sqrt_t sq [0:qte_pkg::SQRT_STAGES];

  always_comb begin
    sq[0].n    = qte_pkg::ONE_Q56 - psq;
    sq[0].rem  = '0;
    sq[0].root = '0;
    sq[0].s    = ps;
    sq[0].sat  = psat;
    sq[0].pos  = ppos;
  end

  genvar k;
  generate
    for (k = 0; k < qte_pkg::SQRT_STAGES; k++) begin : g_sqrt
      qte_sqrt_cell u_cell (.clk(clk), .en(en), .d(sq[k]), .q(sq[k+1]));
    end
  endgenerate

  // fold stages and rotation chains
  qte_pkg::cordic_t roll_c  [0:CORDIC_STAGES];
  qte_pkg::cordic_t yaw_c   [0:CORDIC_STAGES];
  qte_pkg::cordic_t pitch_c [0:CORDIC_STAGES];

  always_ff @(posedge clk) begin
    if (en) begin
      roll_c[0]  <= qte_pkg::cordic_pre(XW'(sinr), XW'(cosr), 1'b0, 1'b0);
      yaw_c[0]   <= qte_pkg::cordic_pre(XW'(siny), XW'(cosy), 1'b0, 1'b0);
      pitch_c[0] <= qte_pkg::cordic_pre(XW'(sq[qte_pkg::SQRT_STAGES].s),
                      {{(XW-RW){1'b0}}, sq[qte_pkg::SQRT_STAGES].root},
                      sq[qte_pkg::SQRT_STAGES].sat, sq[qte_pkg::SQRT_STAGES].pos);
    end
  end

  generate
    for (k = 0; k < CORDIC_STAGES; k++) begin : g_rot
      qte_cordic_cell #(.SHIFT(k)) u_roll (
        .clk(clk), .en(en), .d(roll_c[k]), .q(roll_c[k+1]));
      qte_cordic_cell #(.SHIFT(k)) u_yaw (
        .clk(clk), .en(en), .d(yaw_c[k]), .q(yaw_c[k+1]));
      qte_cordic_cell #(.SHIFT(k)) u_pitch (
        .clk(clk), .en(en), .d(pitch_c[k]), .q(pitch_c[k+1]));
    end
  endgenerate

  // round half up to 12 fraction bits and clamp
  function automatic logic signed [15:0] to_q12(input qte_pkg::cordic_t c,
                                                input logic signed [15:0] lim);
    logic signed [qte_pkg::Z_W:0] t;
    logic signed [qte_pkg::Z_W:0] r;
    logic signed [qte_pkg::Z_W:0] l;
    t = (qte_pkg::Z_W+1)'(c.z) + (qte_pkg::Z_W+1)'(2048);
    r = t >>> 12;
    l = (qte_pkg::Z_W+1)'(lim);
    if (c.zero) begin
      r = '0;
    end else if (r > l) begin
      r = l;
    end else if (r < -l) begin
      r = -l;
    end
    return r[15:0];
  endfunction

  logic [29:0]          ry_dly [0:RY_DLY-1];
  logic signed [15:0]   roll_r, yaw_r, pitch_r;
  logic signed [13:0]   pitch_out;
  logic                 sat_out;

  assign roll_r  = to_q12(roll_c[CORDIC_STAGES], qte_pkg::PI_Q12);
  assign yaw_r   = to_q12(yaw_c[CORDIC_STAGES], qte_pkg::PI_Q12);
  assign pitch_r = to_q12(pitch_c[CORDIC_STAGES], qte_pkg::HALF_PI_Q12);

  always_ff @(posedge clk) begin
    if (en) begin
      ry_dly[0] <= {yaw_r[14:0], roll_r[14:0]};
      for (int i = 1; i < RY_DLY; i++) begin
        ry_dly[i] <= ry_dly[i-1];
      end
      sat_out <= pitch_c[CORDIC_STAGES].sat;
      if (pitch_c[CORDIC_STAGES].sat) begin
        pitch_out <= pitch_c[CORDIC_STAGES].pos ? qte_pkg::HALF_PI_Q12[13:0]
                                                : 14'(-qte_pkg::HALF_PI_Q12);
      end else begin
        pitch_out <= pitch_r[13:0];
      end
    end
  end

  assign m_tdata = {4'b0000, ry_dly[RY_DLY-1][29:15], pitch_out,
                    ry_dly[RY_DLY-1][14:0]};
  assign m_tuser = sat_out;

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_to_euler testbench
// Sends Q1.14 quaternions and checks the roll, pitch and yaw angles and the
// pitch clamp flag against a bit-true predictor kept inside the bench. Covers
// directed corner cases, random unit and gimbal-lock quaternions, raw bit
// patterns, random idling on both sides and a long output hold-off.
// ----------------------------------------------------------------------------
module testbench;

  localparam int  STAGES   = 16;
  localparam int  LATENCY  = STAGES + 34;
  localparam longint ONE28 = 64'sd1 <<< 28;

  typedef struct packed {
    logic signed [14:0] roll;
    logic signed [13:0] pitch;
    logic signed [14:0] yaw;
    logic               sat;
  } angles_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic [0:0]  m_tuser;

  angles_t expected_angles[$];
  int      mismatches = 0;
  int      send_gap_max = 18;
  int      recv_stall_max = 18;
  int      hold_off_cycles = 0;

  longint atan_tab[24] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
                           262123, 131069, 65536, 32768, 16384, 8192, 4096,
                           2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};

  quaternion_to_euler #(.CORDIC_STAGES(STAGES)) u_dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser
  );

  always #5 clk = ~clk;

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // vectoring arctangent, 24 fraction bits
  function automatic longint vector_angle(longint y, longint x);
    longint a = 0;
    longint dx, dy;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      a = (y >= 0) ? 64'sd52707179 : -64'sd52707179;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STAGES && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; a += atan_tab[i];
      end else begin
        x -= dx; y += dy; a -= atan_tab[i];
      end
    end
    return a;
  endfunction

  function automatic longint round_q12(longint a, longint lim);
    longint r = (a + 2048) >>> 12;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic angles_t euler_of(logic [63:0] q);
    longint w = longint'($signed(q[15:0]));
    longint x = longint'($signed(q[31:16]));
    longint y = longint'($signed(q[47:32]));
    longint z = longint'($signed(q[63:48]));
    longint sinp = 2 * (w * y - z * x);
    longint p;
    longint unsigned c;
    angles_t e;
    e.roll = 15'(round_q12(vector_angle(2 * (w * x + y * z),
                                        ONE28 - 2 * (x * x + y * y)), 12868));
    e.yaw  = 15'(round_q12(vector_angle(2 * (w * z + x * y),
                                        ONE28 - 2 * (y * y + z * z)), 12868));
    if (sinp >= ONE28 || sinp <= -ONE28) begin
      p = (sinp > 0) ? 6434 : -6434;
      e.sat = 1'b1;
    end else begin
      c = int_sqrt((64'd1 << 56) - longint'(sinp * sinp));
      p = round_q12(vector_angle(sinp, longint'(c)), 6434);
      e.sat = 1'b0;
    end
    e.pitch = 14'(p);
    return e;
  endfunction

  task automatic send_quat(logic [15:0] w, logic [15:0] x, logic [15:0] y,
                           logic [15:0] z);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= {z, y, x, w};
    do @(posedge clk); while (!s_tready);
    expected_angles.push_back(euler_of({z, y, x, w}));
    @(negedge clk);
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_angles.size() != 0) @(negedge clk);
  endtask

  // random unit quaternion scaled to Q1.14
  task automatic send_unit_quat();
    real c[4];
    real mag = 0.0;
    foreach (c[i]) begin
      c[i] = real'(int'($urandom_range(0, 65535)) - 32768);
      mag += c[i] * c[i];
    end
    if (mag == 0.0) begin
      send_quat(16'sd16384, 0, 0, 0);
    end else begin
      mag = $sqrt(mag);
      send_quat(16'($rtoi(c[0] / mag * 16384.0)), 16'($rtoi(c[1] / mag * 16384.0)),
                16'($rtoi(c[2] / mag * 16384.0)), 16'($rtoi(c[3] / mag * 16384.0)));
    end
  endtask

  // near gimbal lock: pitch sine close to +-1
  task automatic send_gimbal_quat();
    int a = 11585 + int'($urandom_range(0, 6)) - 3;
    int b = 11585 + int'($urandom_range(0, 6)) - 3;
    int s = $urandom_range(0, 1) ? 1 : -1;
    int t = int'($urandom_range(0, 40)) - 20;
    if ($urandom_range(0, 1))
      send_quat(16'(a), 16'(t), 16'(s * b), 16'(-t));
    else
      send_quat(16'(a), 16'(s * b), 16'(t), 16'(-s * a));
  endtask

  task automatic test_directed();
    send_quat(16'sd16384, 0, 0, 0);                    // identity
    send_quat(0, 0, 0, 0);                             // zero vector
    send_quat(0, 16'sd16384, 0, 0);                    // roll of pi
    send_quat(0, 0, 0, 16'sd16384);                    // yaw of pi
    send_quat(0, -16'sd16384, 0, 0);
    send_quat(16'sd1000, -16'sd16000, 0, 0);           // negative x axis, negative sine
    send_quat(16'sd1000, 0, 16'sd8000, -16'sd14000);
    send_quat(16'sd16384, 0, 16'sd8192, 0);            // pitch sine exactly +1
    send_quat(16'sd16384, 0, -16'sd8192, 0);           // pitch sine exactly -1
    send_quat(16'sd11585, 0, 16'sd11585, 0);           // just below +1
    send_quat(16'sd11585, 0, -16'sd11585, 0);
    send_quat(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384);
    send_quat(-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384);
    send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000); // out of range
    send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_quat(16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
    send_quat(16'hffff, 16'h0001, 16'hffff, 16'h0001);
    send_quat(16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192);
    send_quat(16'sd8192, -16'sd8192, 16'sd8192, -16'sd8192);
    wait_drained();
  endtask

  task automatic test_random(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      // stretches with no idling on either side
      if (i % 100 == 50) begin
        send_gap_max = 0; recv_stall_max = 0;
      end else if (i % 100 == 80) begin
        send_gap_max = 18; recv_stall_max = 18;
      end
      k = $urandom_range(0, 9);
      if (k < 6) send_unit_quat();
      else if (k < 8) send_gimbal_quat();
      else send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    end
    send_gap_max = 18; recv_stall_max = 18;
  endtask

  task automatic test_backpressure();
    hold_off_cycles = 200;
    send_gap_max = 0;
    for (int i = 0; i < 80; i++) send_unit_quat();
    send_gap_max = 18;
    wait_drained();
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    int stall;
    angles_t e;
    angles_t got;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off_cycles > 0) begin
        stall = hold_off_cycles;
        hold_off_cycles = 0;
      end else begin
        stall = $urandom_range(0, recv_stall_max);
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      got = {m_tdata[14:0], m_tdata[28:15], m_tdata[43:29], m_tuser[0]};
      if (expected_angles.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer: %h", m_tdata);
      end else begin
        e = expected_angles.pop_front();
        if (got !== e || m_tdata[47:44] !== 4'd0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: roll %0d/%0d pitch %0d/%0d yaw %0d/%0d sat %0b/%0b",
                     e.roll, got.roll, e.pitch, got.pitch, e.yaw, got.yaw,
                     e.sat, got.sat);
        end
      end
      @(negedge clk);
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_random(400);
    test_backpressure();
    wait_drained();
    repeat (LATENCY + 20) @(negedge clk);
    if (mismatches == 0 && expected_angles.size() == 0)
      $display("quaternion_to_euler test passed");
    else
      $display("quaternion_to_euler test failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("quaternion_to_euler test failed");
    $finish;
  end

endmodule

FILE: sim.f
hdl/qte_pkg.sv
hdl/qte_sqrt_cell.sv
hdl/qte_cordic_cell.sv
hdl/quaternion_to_euler.sv
dv/testbench.sv
